### rtl/epoch_seconds_to_calendar_defines.svh
// ----------------------------------------------------------------------------
// Epoch seconds to calendar: assertion macros
// Shared property forms on the block clock, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef EPOCH_SECONDS_TO_CALENDAR_DEFINES_SVH
`define EPOCH_SECONDS_TO_CALENDAR_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define EST_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Antecedent implies consequent in the next cycle.
`define EST_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/est_pkg.sv
// ----------------------------------------------------------------------------
// Epoch seconds to calendar: package
// Constants, shared types and calendar helpers.
// ----------------------------------------------------------------------------
package est_pkg;

   localparam int UNIT_W        = 32;
   localparam int SECS_W        = 32;
   localparam int MICRO_W       = 20;
   localparam int DAYS_W        = 16;
   localparam int QUO_W         = 16;
   localparam int STEP_W        = 4;

   localparam int EPOCH_YEAR    = 1970;
   localparam int SECS_PER_DAY  = 86400;
   localparam int SECS_PER_HOUR = 3600;
   localparam int SECS_PER_MIN  = 60;
   localparam int US_PER_MS     = 1000;
   localparam int MS_MAX        = 999;
   localparam int DAYS_PER_YEAR = 365;
   localparam int SKIPPED_LEAP  = 2100;   // only non-leap century in range
   localparam int LAST_MONTH    = 11;     // December, zero based

   // quotient bits produced by each restoring division
   localparam int DAY_STEPS     = 16;     // days < 2^16
   localparam int HOUR_STEPS    = 5;      // hour < 24
   localparam int MIN_STEPS     = 6;      // minute < 60
   localparam int MS_STEPS      = 11;     // micro / 1000 < 2^11

   typedef struct packed {
      logic [UNIT_W-1:0] a;
      logic [UNIT_W-1:0] b;
   } unit_req_type;

   typedef struct packed {
      logic              ge;
      logic [UNIT_W-1:0] diff;
   } unit_rsp_type;

   // packed so that year sits in the low bits
   typedef struct packed {
      logic [9:0]  millisecond;
      logic [5:0]  second;
      logic [5:0]  minute;
      logic [4:0]  hour;
      logic [4:0]  day_of_month;
      logic [3:0]  month;
      logic [11:0] year;
   } result_type;

   // Gregorian rule, valid over 1970..2106
   function automatic logic is_leap(input logic [11:0] yr);
      return (yr[1:0] == 2'b00) && (yr != 12'(SKIPPED_LEAP));
   endfunction

   function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
      logic [4:0] len;
      unique case (mon)
         4'd1:                      len = leap ? 5'd29 : 5'd28;
         4'd3, 4'd5, 4'd8, 4'd10:  len = 5'd30;
         default:                   len = 5'd31;
      endcase
      return len;
   endfunction

endpackage

### rtl/est_cmp_sub.sv
// ----------------------------------------------------------------------------
// Epoch seconds to calendar: compare-subtract unit
// Single shared a >= b test and a - b difference.
// ----------------------------------------------------------------------------
module est_cmp_sub (
   input  est_pkg::unit_req_type unit_req,
   output est_pkg::unit_rsp_type unit_rsp
);

   assign unit_rsp.ge   = (unit_req.a >= unit_req.b);
   assign unit_rsp.diff = unit_req.a - unit_req.b;

endmodule

### rtl/est_seq.sv
// ----------------------------------------------------------------------------
// Epoch seconds to calendar: sequencer
// Drives the shared unit through day, year, month, time and ms phases.
// ----------------------------------------------------------------------------
module est_seq (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic [est_pkg::SECS_W-1:0]      req_secs,
   input  logic [est_pkg::MICRO_W-1:0]     req_micro,
   output logic                            ready,
   input  logic                            out_free,
   output logic                            done,
   output est_pkg::result_type             result,
   output est_pkg::unit_req_type           unit_req,
   input  est_pkg::unit_rsp_type           unit_rsp
);

   typedef enum logic [2:0] {
      S_IDLE, S_DAYS, S_YEAR, S_MONTH, S_HOUR, S_MIN, S_MS, S_DONE
   } state_type;

   state_type                         state_ff, state_in;
   logic [est_pkg::UNIT_W-1:0]        acc_ff, acc_in;
   logic [est_pkg::QUO_W-1:0]         quo_ff, quo_in;
   logic [est_pkg::STEP_W-1:0]        step_ff, step_in;
   logic [est_pkg::DAYS_W-1:0]        days_ff, days_in;
   logic [est_pkg::MICRO_W-1:0]       micro_ff, micro_in;
   logic [11:0]                       year_ff, year_in;
   logic [3:0]                        month_ff, month_in;
   logic [4:0]                        hour_ff, hour_in;
   logic [5:0]                        minute_ff, minute_in;
   logic [5:0]                        second_ff, second_in;
   logic [9:0]                        ms_ff, ms_in;

   logic                              leap;
   logic [est_pkg::QUO_W-1:0]         quo_next;
   logic [est_pkg::UNIT_W-1:0]        acc_next;

   assign leap     = est_pkg::is_leap(year_ff);
   // restoring division step: keep difference and set quotient bit when it fits
   assign quo_next = unit_rsp.ge ? (quo_ff | (est_pkg::QUO_W'(1) << step_ff)) : quo_ff;
   assign acc_next = unit_rsp.ge ? unit_rsp.diff : acc_ff;

   always_comb begin
      state_in   = state_ff;
      acc_in     = acc_ff;
      quo_in     = quo_ff;
      step_in    = step_ff;
      days_in    = days_ff;
      micro_in   = micro_ff;
      year_in    = year_ff;
      month_in   = month_ff;
      hour_in    = hour_ff;
      minute_in  = minute_ff;
      second_in  = second_ff;
      ms_in      = ms_ff;
      unit_req.a = acc_ff;
      unit_req.b = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               acc_in   = req_secs;
               micro_in = req_micro;
               quo_in   = '0;
               step_in  = est_pkg::STEP_W'(est_pkg::DAY_STEPS - 1);
               state_in = S_DAYS;
            end
         end
         S_DAYS: begin
            unit_req.b = est_pkg::UNIT_W'(est_pkg::SECS_PER_DAY) << step_ff;
            acc_in     = acc_next;
            quo_in     = quo_next;
            if (step_ff == '0) begin
               days_in  = quo_next;     // acc now holds second of day
               year_in  = 12'(est_pkg::EPOCH_YEAR);
               state_in = S_YEAR;
            end else begin
               step_in = step_ff - 1'b1;
            end
         end
         S_YEAR: begin
            unit_req.a = est_pkg::UNIT_W'(days_ff);
            unit_req.b = est_pkg::UNIT_W'(est_pkg::DAYS_PER_YEAR) +
                         est_pkg::UNIT_W'(leap);
            if (unit_rsp.ge) begin
               days_in = unit_rsp.diff[est_pkg::DAYS_W-1:0];
               year_in = year_ff + 12'd1;
            end else begin
               month_in = '0;
               state_in = S_MONTH;
            end
         end
         S_MONTH: begin
            unit_req.a = est_pkg::UNIT_W'(days_ff);
            unit_req.b = est_pkg::UNIT_W'(est_pkg::month_len(month_ff, leap));
            if (unit_rsp.ge && (month_ff != 4'(est_pkg::LAST_MONTH))) begin
               days_in  = unit_rsp.diff[est_pkg::DAYS_W-1:0];
               month_in = month_ff + 4'd1;
            end else begin
               quo_in   = '0;
               step_in  = est_pkg::STEP_W'(est_pkg::HOUR_STEPS - 1);
               state_in = S_HOUR;
            end
         end
         S_HOUR: begin
            unit_req.b = est_pkg::UNIT_W'(est_pkg::SECS_PER_HOUR) << step_ff;
            acc_in     = acc_next;
            quo_in     = quo_next;
            if (step_ff == '0) begin
               hour_in  = quo_next[4:0];
               quo_in   = '0;
               step_in  = est_pkg::STEP_W'(est_pkg::MIN_STEPS - 1);
               state_in = S_MIN;
            end else begin
               step_in = step_ff - 1'b1;
            end
         end
         S_MIN: begin
            unit_req.b = est_pkg::UNIT_W'(est_pkg::SECS_PER_MIN) << step_ff;
            acc_in     = acc_next;
            quo_in     = quo_next;
            if (step_ff == '0) begin
               minute_in = quo_next[5:0];
               second_in = acc_next[5:0];
               acc_in    = est_pkg::UNIT_W'(micro_ff);
               quo_in    = '0;
               step_in   = est_pkg::STEP_W'(est_pkg::MS_STEPS - 1);
               state_in  = S_MS;
            end else begin
               step_in = step_ff - 1'b1;
            end
         end
         S_MS: begin
            unit_req.b = est_pkg::UNIT_W'(est_pkg::US_PER_MS) << step_ff;
            acc_in     = acc_next;
            quo_in     = quo_next;
            if (step_ff == '0) begin
               // over-range microseconds clamp, never carry into seconds
               ms_in    = (quo_next > est_pkg::QUO_W'(est_pkg::MS_MAX)) ?
                          10'(est_pkg::MS_MAX) : quo_next[9:0];
               state_in = S_DONE;
            end else begin
               step_in = step_ff - 1'b1;
            end
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      acc_ff    <= acc_in;
      quo_ff    <= quo_in;
      step_ff   <= step_in;
      days_ff   <= days_in;
      micro_ff  <= micro_in;
      year_ff   <= year_in;
      month_ff  <= month_in;
      hour_ff   <= hour_in;
      minute_ff <= minute_in;
      second_ff <= second_in;
      ms_ff     <= ms_in;
   end

   assign ready = (state_ff == S_IDLE);
   assign done  = (state_ff == S_DONE);

   assign result.year         = year_ff;
   assign result.month        = month_ff + 4'd1;
   assign result.day_of_month = days_ff[4:0] + 5'd1;
   assign result.hour         = hour_ff;
   assign result.minute       = minute_ff;
   assign result.second       = second_ff;
   assign result.millisecond  = ms_ff;

endmodule

### rtl/epoch_seconds_to_calendar.sv
// ----------------------------------------------------------------------------
// Epoch seconds to calendar: top level
// Converts seconds since 1970 plus microseconds to a calendar date and time.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one request: seconds since 1970-01-01 00:00:00 and a
//   sub-second microsecond count. rsp_* returns exactly one result per
//   request: year, month, day of month, hour, minute, second, millisecond.
//   A request is taken on a clock edge with req_tvalid and req_tready high.
//   The block holds one request at a time; req_tready stays low while it
//   works. The conversion runs on the single compare-subtract unit: 16
//   steps for the day count, one step per year and per month, then
//   5 + 6 + 11 steps for hour, minute and millisecond.
//   The result sits in an output register; a stalled receiver holds it
//   there while the next request is already converted. A finished
//   conversion then waits until the register is free before taking more.
//   Reset (synchronous, active high) idles the sequencer and clears
//   rsp_tvalid. The other registers are not reset.
// ----------------------------------------------------------------------------
`include "epoch_seconds_to_calendar_defines.svh"

module epoch_seconds_to_calendar (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,   // epoch_seconds[31:0], micro_part[51:32], zero pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata    // year[11:0], month[15:12], day_of_month[20:16],
                                    // hour[25:21], minute[31:26], second[37:32],
                                    // millisecond[47:38]
);

   est_pkg::unit_req_type unit_req;
   est_pkg::unit_rsp_type unit_rsp;
   est_pkg::result_type   result;
   logic                  done;
   logic                  out_free;

   logic                  out_valid_ff, out_valid_in;
   est_pkg::result_type   out_data_ff, out_data_in;

   // register is free when empty or being drained this cycle
   assign out_free = !out_valid_ff || rsp_tready;

   est_cmp_sub u_cmp_sub (
      .unit_req (unit_req),
      .unit_rsp (unit_rsp)
   );

   est_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_secs  (req_tdata[31:0]),
      .req_micro (req_tdata[51:32]),
      .ready     (req_tready),
      .out_free  (out_free),
      .done      (done),
      .result    (result),
      .unit_req  (unit_req),
      .unit_rsp  (unit_rsp)
   );

   always_comb begin
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (done && out_free) begin
         out_valid_in = 1'b1;
         out_data_in  = result;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      out_data_ff <= out_data_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   // busy right after taking a request
   `EST_ASSERT_NEXT(a_busy_after_req, req_tvalid && req_tready, !req_tready, "ready after accept")
   // calendar fields in range
   `EST_ASSERT_SAME(a_date_range, rsp_tvalid, (rsp_tdata[15:12] >= 4'd1) && (rsp_tdata[15:12] <= 4'd12) && (rsp_tdata[20:16] >= 5'd1), "date field out of range")
   // time of day fields in range
   `EST_ASSERT_SAME(a_time_range, rsp_tvalid, (rsp_tdata[25:21] <= 5'd23) && (rsp_tdata[31:26] <= 6'd59) && (rsp_tdata[37:32] <= 6'd59) && (rsp_tdata[47:38] <= 10'd999), "time field out of range")

endmodule
